// ===== rtl/vlan_membership_table_core_assert.svh =====
// Assertion macros used by the VLAN membership table core.
`ifndef VLAN_MEMBERSHIP_TABLE_CORE_ASSERT_SVH
`define VLAN_MEMBERSHIP_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define VMT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vmt assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define VMT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vmt assertion failed");

`endif

// ===== rtl/vmt_pkg.sv =====
// Types and constants of the VLAN membership table.
package vmt_pkg;

   localparam int VID_W      = 12;
   localparam int PORT_W     = 8;
   localparam int STATUS_W   = 2;
   // widest entry index and member count over the supported parameter range
   localparam int IDX_MAX_W  = 12;
   localparam int PCNT_MAX_W = 9;

   localparam logic KIND_ADD   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] ADD_ADDED      = 2'd0;
   localparam logic [STATUS_W-1:0] ADD_MEMBER     = 2'd1;
   localparam logic [STATUS_W-1:0] ADD_TABLE_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ADD_LIST_FULL  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SCAN
   } vmt_state_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic [VID_W-1:0]      vid;
      logic [IDX_MAX_W-1:0]  idx;
      logic [PCNT_MAX_W-1:0] pcnt;
   } vmt_tok_type;

   // entry update broadcast to all cells
   typedef struct packed {
      logic                  we;
      logic                  set_vid;
      logic [IDX_MAX_W-1:0]  idx;
      logic [VID_W-1:0]      vid;
      logic [PCNT_MAX_W-1:0] pcnt;
   } vmt_wr_type;

endpackage

// ===== rtl/vmt_cell.sv =====
// One table entry cell: holds a VLAN id and member count, checks the passing token.
module vmt_cell #(
   parameter int INDEX  = 0,
   parameter int CNT_W  = 7,
   parameter int PCNT_W = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [CNT_W-1:0]   entry_count,
   input  vmt_pkg::vmt_tok_type up_tok,
   output vmt_pkg::vmt_tok_type dn_tok,
   input  vmt_pkg::vmt_wr_type  wr
);
   import vmt_pkg::*;

   logic [VID_W-1:0]  vid_ff;
   logic [PCNT_W-1:0] pcnt_ff;
   vmt_tok_type       tok_ff;
   vmt_tok_type       tok_in;
   logic              live;
   logic              match;

   assign live  = CNT_W'(INDEX) < entry_count;
   assign match = up_tok.valid && !up_tok.hit && live && (vid_ff == up_tok.vid);

   always_comb begin
      tok_in = up_tok;
      if (match) begin
         tok_in.hit  = 1'b1;
         tok_in.idx  = IDX_MAX_W'(INDEX);
         tok_in.pcnt = PCNT_MAX_W'(pcnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.we && (wr.idx == IDX_MAX_W'(INDEX))) begin
         if (wr.set_vid) begin
            vid_ff <= wr.vid;
         end
         pcnt_ff <= wr.pcnt[PCNT_W-1:0];
      end
   end

   assign dn_tok = tok_ff;

endmodule

// ===== rtl/vlan_membership_table_core.sv =====
// Top level of the VLAN membership table: controller, entry cell chain, port slot memory.
//
// Issue an item by raising start while busy is low; busy then stays high until the
// item is answered (a query for VLAN 0 never raises it), and the answer appears on
// rsp_allowed / rsp_add_status for one cycle with rsp_strobe high. There is no way
// to hold a result off: capture it in the strobe cycle. A query for VLAN 0 is
// answered without a search: its answer is registered and shows in the next cycle.
// Every other item first sends a search token down the chain of TABLE_ENTRIES entry
// cells, one cell per cycle, and the token always passes the whole chain. If an
// entry is found (or created by an add), its member ports are read from the slot
// memory one per cycle, stopping at the first match, at the end of the list, or at
// once for a new, empty list. The next item may be started in the cycle the
// previous result shows.
// Entries are never removed. The slot memory needs no clearing: only entries below
// the entry count and slots below a member count are read.
module vlan_membership_table_core #(
   parameter int TABLE_ENTRIES = 64,
   parameter int PORT_SLOTS    = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [vmt_pkg::PORT_W-1:0]    req_port,
   input  logic [vmt_pkg::VID_W-1:0]     req_vlan_id,
   output logic                          rsp_strobe,
   output logic                          rsp_allowed,
   output logic [vmt_pkg::STATUS_W-1:0]  rsp_add_status
);
   import vmt_pkg::*;

`include "vlan_membership_table_core_assert.svh"

   localparam int IDX_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(TABLE_ENTRIES + 1);
   localparam int PCNT_W      = $clog2(PORT_SLOTS + 1);
   localparam int SLOTS_TOTAL = TABLE_ENTRIES * PORT_SLOTS;
   localparam int ADDR_W      = (SLOTS_TOTAL > 1) ? $clog2(SLOTS_TOTAL) : 1;

   // controller state
   vmt_state_type state_ff, state_in;

   // latched item
   logic                kind_ff, kind_in;
   logic [PORT_W-1:0]   port_ff, port_in;
   logic [VID_W-1:0]    vid_ff, vid_in;

   // table bookkeeping
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    ent_ff, ent_in;     // entry being scanned
   logic [PCNT_W-1:0]   n_ff, n_in;         // its member count
   logic [PCNT_W-1:0]   j_ff, j_in;         // next slot to read
   logic [ADDR_W-1:0]   base_ff, base_in;   // first slot address of the entry
   logic                pend_ff, pend_in;   // slot read data valid next cycle

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_allowed_ff, rsp_allowed_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // cell chain
   vmt_tok_type         launch_ff, launch_in;
   vmt_tok_type         tok [TABLE_ENTRIES+1];
   vmt_tok_type         tok_end;
   vmt_wr_type          wr_bus;

   // slot memory
   logic [PORT_W-1:0]   slot_mem [SLOTS_TOTAL];
   logic [PORT_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;

   logic                accept;
   logic                table_full;
   logic                hit_now;
   logic                scan_done;
   logic [IDX_W-1:0]    new_ent;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign tok_end  = tok[TABLE_ENTRIES];
   assign tok[0]   = launch_ff;

   assign table_full = (count_ff == CNT_W'(TABLE_ENTRIES));
   // found entry, or the slot where a new one goes
   assign new_ent    = tok_end.hit ? tok_end.idx[IDX_W-1:0] : count_ff[IDX_W-1:0];
   assign hit_now    = pend_ff && (rd_data_ff == port_ff);
   assign scan_done  = hit_now || (!pend_ff && (j_ff >= n_ff));
   assign rd_addr    = base_ff + ADDR_W'(j_ff);

   for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      vmt_cell #(
         .INDEX  (gi),
         .CNT_W  (CNT_W),
         .PCNT_W (PCNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .entry_count (count_ff),
         .up_tok      (tok[gi]),
         .dn_tok      (tok[gi+1]),
         .wr          (wr_bus)
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !((req_kind == KIND_QUERY) && (req_vlan_id == '0))) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tok_end.valid) begin
               if (tok_end.hit || ((kind_ff == KIND_ADD) && !table_full)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      kind_in        = kind_ff;
      port_in        = port_ff;
      vid_in         = vid_ff;
      count_in       = count_ff;
      ent_in         = ent_ff;
      n_in           = n_ff;
      j_in           = j_ff;
      base_in        = base_ff;
      pend_in        = 1'b0;
      rsp_valid_in   = 1'b0;
      rsp_allowed_in = 1'b0;
      rsp_status_in  = ADD_ADDED;
      launch_in      = '0;
      wr_bus         = '0;
      mem_we         = 1'b0;
      mem_waddr      = base_ff + ADDR_W'(n_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               port_in = req_port;
               vid_in  = req_vlan_id;
               if ((req_kind == KIND_QUERY) && (req_vlan_id == '0)) begin
                  // untagged traffic is always allowed
                  rsp_valid_in   = 1'b1;
                  rsp_allowed_in = 1'b1;
               end else begin
                  launch_in.valid = 1'b1;
                  launch_in.vid   = req_vlan_id;
               end
            end
         end
         ST_SEARCH: begin
            if (tok_end.valid) begin
               ent_in  = new_ent;
               base_in = ADDR_W'(new_ent) * ADDR_W'(PORT_SLOTS);
               j_in    = '0;
               if (tok_end.hit) begin
                  n_in = tok_end.pcnt[PCNT_W-1:0];
               end else if (kind_ff == KIND_QUERY) begin
                  rsp_valid_in = 1'b1;
               end else if (table_full) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ADD_TABLE_FULL;
               end else begin
                  // open a new entry with an empty port list
                  n_in           = '0;
                  count_in       = count_ff + 1'b1;
                  wr_bus.we      = 1'b1;
                  wr_bus.set_vid = 1'b1;
                  wr_bus.idx     = IDX_MAX_W'(new_ent);
                  wr_bus.vid     = vid_ff;
                  wr_bus.pcnt    = '0;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               rsp_valid_in = 1'b1;
               if (kind_ff == KIND_QUERY) begin
                  rsp_allowed_in = hit_now;
               end else if (hit_now) begin
                  rsp_status_in = ADD_MEMBER;
               end else if (n_ff == PCNT_W'(PORT_SLOTS)) begin
                  rsp_status_in = ADD_LIST_FULL;
               end else begin
                  // append at the end of the list
                  mem_we      = 1'b1;
                  wr_bus.we   = 1'b1;
                  wr_bus.idx  = IDX_MAX_W'(ent_ff);
                  wr_bus.pcnt = PCNT_MAX_W'(n_ff + 1'b1);
               end
            end else if (j_ff < n_ff) begin
               pend_in = 1'b1;
               j_in    = j_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         launch_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         launch_ff    <= launch_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      port_ff        <= port_in;
      vid_ff         <= vid_in;
      ent_ff         <= ent_in;
      n_ff           <= n_in;
      j_ff           <= j_in;
      base_ff        <= base_in;
      rsp_allowed_ff <= rsp_allowed_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= port_ff;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_allowed    = rsp_allowed_ff;
   assign rsp_add_status = rsp_status_ff;

   `VMT_ASSERT_IMPL(a_count_range, 1'b1, count_ff <= CNT_W'(TABLE_ENTRIES))
   `VMT_ASSERT_IMPL(a_end_in_search, tok_end.valid, state_ff == ST_SEARCH)
   `VMT_ASSERT_IMPL(a_append_room, mem_we, n_ff < PCNT_W'(PORT_SLOTS))
   `VMT_ASSERT_NEXT(a_launch_on_accept, accept && (req_kind == KIND_ADD), launch_ff.valid)

endmodule

// ===== verif/vlan_membership_table_core_test.sv =====
// Self-checking testbench for the VLAN membership table core.
module vlan_membership_table_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import vmt_pkg::*;

   localparam int ENTRIES     = 64;
   localparam int SLOTS       = 32;
   localparam int VID_POOL    = 80;   // more VLANs than entries so the table fills up
   localparam int RANDOM_N    = 1400;
   localparam int TAIL_CYCLES = ENTRIES + SLOTS + 16;
   localparam int STALL_LIMIT = 5000; // above the longest item plus the longest sender gap

   // one outstanding answer, with the item that caused it for messages
   typedef struct {
      int                  seq;
      logic                kind;
      logic [PORT_W-1:0]   port;
      logic [VID_W-1:0]    vid;
      logic                allowed;
      logic [STATUS_W-1:0] status;
   } answer_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic                req_kind    = KIND_ADD;
   logic [PORT_W-1:0]   req_port    = '0;
   logic [VID_W-1:0]    req_vlan_id = '0;
   logic                busy;
   logic                rsp_strobe;
   logic                rsp_allowed;
   logic [STATUS_W-1:0] rsp_add_status;

   // shadow copy of the membership table
   logic [VID_W-1:0]    shadow_vid   [ENTRIES];
   int                  shadow_members [ENTRIES];
   logic [PORT_W-1:0]   shadow_ports [ENTRIES][SLOTS];
   int                  shadow_used = 0;

   answer_type          pending_answers[$];
   logic [VID_W-1:0]    vid_pool[VID_POOL];
   logic [PORT_W-1:0]   port_order[256];
   int                  items_sent  = 0;
   int                  mismatches  = 0;
   int                  stall_count = 0;
   bit                  steady      = 1'b0;   // no sender gaps while set

   vlan_membership_table_core #(
      .TABLE_ENTRIES(ENTRIES),
      .PORT_SLOTS(SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_port(req_port),
      .req_vlan_id(req_vlan_id),
      .rsp_strobe(rsp_strobe),
      .rsp_allowed(rsp_allowed),
      .rsp_add_status(rsp_add_status)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // index of the entry holding vid, -1 when absent
   function automatic int find_vlan(logic [VID_W-1:0] vid);
      for (int i = 0; i < shadow_used; i++)
         if (shadow_vid[i] == vid) return i;
      return -1;
   endfunction

   function automatic bit has_port(int e, logic [PORT_W-1:0] port);
      for (int j = 0; j < shadow_members[e]; j++)
         if (shadow_ports[e][j] == port) return 1'b1;
      return 1'b0;
   endfunction

   // 1 when vid is among the first used pool entries
   function automatic bit in_pool(logic [VID_W-1:0] vid, int used);
      for (int i = 0; i < used; i++)
         if (vid_pool[i] == vid) return 1'b1;
      return 1'b0;
   endfunction

   // applies one item to the shadow table and returns its answer
   function automatic answer_type apply_membership(logic kind, logic [PORT_W-1:0] port,
                                                   logic [VID_W-1:0] vid);
      answer_type ans;
      int         e;
      ans.kind    = kind;
      ans.port    = port;
      ans.vid     = vid;
      ans.allowed = 1'b0;
      ans.status  = ADD_ADDED;
      e = find_vlan(vid);
      if (kind == KIND_QUERY) begin
         // untagged traffic is always let through
         if (vid == '0) ans.allowed = 1'b1;
         else if (e >= 0 && has_port(e, port)) ans.allowed = 1'b1;
      end else begin
         if (e < 0) begin
            if (shadow_used >= ENTRIES) begin
               ans.status = ADD_TABLE_FULL;
            end else begin
               e = shadow_used;
               shadow_vid[e]     = vid;
               shadow_members[e] = 0;
               shadow_used++;
            end
         end
         if (ans.status == ADD_ADDED) begin
            if (has_port(e, port)) begin
               ans.status = ADD_MEMBER;
            end else if (shadow_members[e] >= SLOTS) begin
               ans.status = ADD_LIST_FULL;
            end else begin
               shadow_ports[e][shadow_members[e]] = port;
               shadow_members[e]++;
            end
         end
      end
      return ans;
   endfunction

   // drives one item, waits for the handshake, then maybe idles for a while
   task automatic send_item(input logic kind, input logic [PORT_W-1:0] port,
                            input logic [VID_W-1:0] vid);
      answer_type  ans;
      int unsigned roll;
      int unsigned gap;
      start       <= 1'b1;
      req_kind    <= kind;
      req_port    <= port;
      req_vlan_id <= vid;
      do @(posedge clock); while (busy !== 1'b0);
      ans     = apply_membership(kind, port, vid);
      ans.seq = items_sent;
      pending_answers.push_back(ans);
      items_sent++;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) gap = 0;
      else if (roll < 88) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 24);
      else gap = $urandom_range(60, 300);
      // start stays high across back-to-back items
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   task automatic shuffle_ports();
      int          k;
      logic [PORT_W-1:0] t;
      for (int i = 0; i < 256; i++) port_order[i] = i[PORT_W-1:0];
      for (int i = 255; i > 0; i--) begin
         k             = $urandom_range(0, i);
         t             = port_order[i];
         port_order[i] = port_order[k];
         port_order[k] = t;
      end
   endtask

   // a VLAN id that has no entry yet
   function automatic logic [VID_W-1:0] fresh_vid();
      logic [VID_W-1:0] v;
      do v = VID_W'($urandom_range(1, 4095)); while (find_vlan(v) >= 0);
      return v;
   endfunction

   // field extremes, untagged VLAN, member / non-member, absent VLAN
   task automatic test_directed();
      send_item(KIND_QUERY, 8'd0,   12'd0);      // untagged, empty table
      send_item(KIND_QUERY, 8'd255, 12'd0);
      send_item(KIND_QUERY, 8'd0,   12'd4095);   // absent VLAN
      send_item(KIND_ADD,   8'd0,   12'd0);      // entry for id 0 is created
      send_item(KIND_ADD,   8'd0,   12'd0);      // already a member
      send_item(KIND_QUERY, 8'd17,  12'd0);      // id 0 answers allowed anyway
      send_item(KIND_ADD,   8'd255, 12'd4095);
      send_item(KIND_ADD,   8'd255, 12'd4095);
      send_item(KIND_QUERY, 8'd255, 12'd4095);
      send_item(KIND_QUERY, 8'd254, 12'd4095);
      send_item(KIND_ADD,   8'd0,   12'd4095);
      send_item(KIND_QUERY, 8'd0,   12'd4095);
      send_item(KIND_QUERY, 8'd255, 12'd1);
      send_item(KIND_ADD,   8'h55,  12'hAAA);
      send_item(KIND_ADD,   8'hAA,  12'h555);
      send_item(KIND_QUERY, 8'h55,  12'hAAA);
      send_item(KIND_QUERY, 8'hAA,  12'hAAA);
      send_item(KIND_QUERY, 8'hAA,  12'h555);
   endtask

   // fill one port list to the brim, then overflow it
   task automatic test_port_list_full();
      logic [VID_W-1:0] vid;
      vid = fresh_vid();
      shuffle_ports();
      for (int i = 0; i < SLOTS; i++) send_item(KIND_ADD, port_order[i], vid);
      send_item(KIND_ADD,   port_order[SLOTS],     vid);   // list full
      send_item(KIND_ADD,   port_order[0],         vid);   // member wins over full
      send_item(KIND_QUERY, port_order[SLOTS - 1], vid);   // last slot is searched
      send_item(KIND_QUERY, port_order[SLOTS],     vid);
      // hold off until the block has answered everything
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int unsigned      roll;
      int               e;
      logic [VID_W-1:0] vid;
      logic [PORT_W-1:0] port;
      for (int i = 0; i < VID_POOL; i++) begin
         do vid = VID_W'($urandom_range(0, 4095));
         while (vid == 12'd0 || find_vlan(vid) >= 0 || in_pool(vid, i));
         vid_pool[i] = vid;
      end
      vid_pool[VID_POOL - 1] = 12'd0;
      for (int n = 0; n < RANDOM_N; n++) begin
         if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         // a handful of hot VLANs collect most adds so their lists fill up
         if ($urandom_range(0, 9) < 4) vid = vid_pool[$urandom_range(0, 3)];
         else vid = vid_pool[$urandom_range(0, VID_POOL - 1)];
         if (roll < 45) begin
            if ($urandom_range(0, 1)) port = PORT_W'($urandom_range(0, 47));
            else port = PORT_W'($urandom_range(0, 255));
            send_item(KIND_ADD, port, vid);
         end else if (roll < 85) begin
            e = find_vlan(vid);
            if (e >= 0 && shadow_members[e] > 0 && $urandom_range(0, 1))
               port = shadow_ports[e][$urandom_range(0, shadow_members[e] - 1)];
            else
               port = PORT_W'($urandom_range(0, 255));
            send_item(KIND_QUERY, port, vid);
         end else begin
            send_item(1'($urandom_range(0, 1)), PORT_W'($urandom_range(0, 255)),
                      VID_W'($urandom_range(0, 4095)));
         end
      end
      steady = 1'b0;
   endtask

   // top the table up, then push adds and queries for absent VLANs
   task automatic test_table_full();
      logic [VID_W-1:0] vid;
      int               e;
      while (shadow_used < ENTRIES)
         send_item(KIND_ADD, PORT_W'($urandom_range(0, 255)), fresh_vid());
      for (int i = 0; i < 6; i++) begin
         vid = fresh_vid();
         send_item(KIND_ADD,   PORT_W'($urandom_range(0, 255)), vid);
         send_item(KIND_QUERY, PORT_W'($urandom_range(0, 255)), vid);
      end
      send_item(KIND_QUERY, PORT_W'($urandom_range(0, 255)), 12'd0);
      e = $urandom_range(0, ENTRIES - 1);
      send_item(KIND_QUERY, shadow_ports[e][0], shadow_vid[e]);
      send_item(KIND_ADD, PORT_W'($urandom_range(0, 255)), shadow_vid[e]);
   endtask

   // result checker: the receiver cannot stall, every strobe is taken
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: allowed=%0b add_status=%0d",
                        rsp_allowed, rsp_add_status);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_allowed !== want.allowed || rsp_add_status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("item %0d kind=%0b port=%0d vlan=%0d: expected %0b/%0d, got %0b/%0d",
                           want.seq, want.kind, want.port, want.vid, want.allowed,
                           want.status, rsp_allowed, rsp_add_status);
            end
         end
      end
   end

   // watchdog: consecutive cycles with neither an item taken nor a result given
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_port_list_full();
      test_random_traffic();
      test_table_full();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      mismatches += pending_answers.size();
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
